// ===== src/srb_pkg.sv =====
// shared types and constants of the sequence reorder buffer
`default_nettype none

package srb_pkg;

	// field widths
	localparam int SEQ_W    = 32;
	localparam int HANDLE_W = 16;

	// slot store geometry
	localparam int SLOT_COUNT = 64;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

	// parameter defaults
	localparam int DEF_REORDER_WINDOW = 63;
	localparam int DEF_HANDLE_BITS    = 16;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_DELIVERED = 2'd0,
		STATUS_WINDOW    = 2'd1,
		STATUS_DUPLICATE = 2'd2
	} status_t;

	// drain sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== src/srb_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module srb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/sequence_reorder_buffer.sv =====
// Sequence reorder buffer: takes packets in any order, hands them out in sequence order.
//
// Input channel (in_valid / in_stall) carries seq_num and pkt_handle. Output channel
// (out_valid / out_stall) carries out_handle, out_seq, status and last; last marks the
// final result caused by one input transfer. A packet behind the expected number or
// more than the window ahead of it comes back at once with the out-of-window status,
// one already buffered in its slot with the duplicate status. Others are stored in a
// 64-entry handle ram at slot seq_num mod 64 and cause no result until the expected
// number arrives; then the unbroken run of buffered packets is delivered.
// Each delivered packet passes a read state for the handle ram read and then an output
// state that loads the output register, which waits while the output is stalled; the
// input stays stalled until the whole run is delivered. The input is taken only when
// the output register is free or being emptied, so a stalled receiver stalls the input.
// Reset clears the expected number to zero and all slot valid bits at once; the block
// is ready to take input as soon as reset is released.
`default_nettype none

module sequence_reorder_buffer #(
	parameter int REORDER_WINDOW = srb_pkg::DEF_REORDER_WINDOW,
	parameter int HANDLE_BITS    = srb_pkg::DEF_HANDLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [srb_pkg::SEQ_W-1:0]     seq_num,
	input  wire logic [srb_pkg::HANDLE_W-1:0]  pkt_handle,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [srb_pkg::HANDLE_W-1:0]  out_handle,
	output logic      [srb_pkg::SEQ_W-1:0]     out_seq,
	output srb_pkg::status_t                   status,
	output logic                               last
);

	import srb_pkg::*;

	// window capped so every buffered number owns a distinct slot
	localparam int EFF_WIN_I = (REORDER_WINDOW > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : REORDER_WINDOW;
	localparam logic [SEQ_W-1:0] EFF_WINDOW = SEQ_W'(EFF_WIN_I);
	localparam int HMASK_BITS = (HANDLE_BITS > HANDLE_W) ? HANDLE_W : HANDLE_BITS;
	localparam logic [HANDLE_W-1:0] HANDLE_MASK =
		HANDLE_W'({HANDLE_W{1'b1}} >> (HANDLE_W - HMASK_BITS));

	state_t                state_q, state_d;
	logic [SEQ_W-1:0]      expected_q;
	logic [SLOT_COUNT-1:0] slot_valid_q;

	logic [SEQ_W-1:0]      seq_s1;
	logic                  last_s1;

	logic                  out_valid_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [SEQ_W-1:0]      out_seq_q;
	status_t               status_q;
	logic                  last_q;

	logic [SEQ_W-1:0]      seq_dist;
	logic                  out_of_window;
	logic                  dup;
	logic [SLOT_BITS-1:0]  in_slot;
	logic [SLOT_BITS-1:0]  exp_slot;
	logic [SLOT_BITS-1:0]  nxt_slot;
	logic [HANDLE_W-1:0]   in_handle;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  out_free;

	logic                  ram_we;
	logic                  ram_re;
	logic                  drop_load;
	logic                  deliver_load;
	logic [HANDLE_W-1:0]   ram_rdata;

	// classification of the arriving packet
	assign seq_dist      = seq_num - expected_q;
	assign out_of_window = seq_dist > EFF_WINDOW;
	assign in_slot       = seq_num[SLOT_BITS-1:0];
	assign dup           = slot_valid_q[in_slot];
	assign exp_slot      = expected_q[SLOT_BITS-1:0];
	assign nxt_slot      = exp_slot + SLOT_BITS'(1);
	assign in_handle     = pkt_handle & HANDLE_MASK;

	// handshakes
	assign out_free = !out_valid_q || !out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && !out_of_window && !dup && (seq_dist == '0)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = last_s1 ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall     = 1'b1;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		drop_load    = 1'b0;
		deliver_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = !out_free;
				ram_we    = in_xfer && !out_of_window && !dup;
				drop_load = in_xfer && (out_of_window || dup);
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_OUT: begin
				deliver_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// state, expected number and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expected_q   <= '0;
			slot_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				slot_valid_q[in_slot] <= 1'b1;
			end
			if (ram_re) begin
				slot_valid_q[exp_slot] <= 1'b0;
				expected_q             <= expected_q + SEQ_W'(1);
			end
		end
	end

	// read stage: number and run end of the packet being fetched
	always_ff @(posedge clk) begin
		if (ram_re) begin
			seq_s1  <= expected_q;
			last_s1 <= !slot_valid_q[nxt_slot];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drop_load || deliver_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (drop_load) begin
			out_handle_q <= in_handle;
			out_seq_q    <= seq_num;
			status_q     <= out_of_window ? STATUS_WINDOW : STATUS_DUPLICATE;
			last_q       <= 1'b1;
		end else if (deliver_load) begin
			out_handle_q <= ram_rdata;
			out_seq_q    <= seq_s1;
			status_q     <= STATUS_DELIVERED;
			last_q       <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_handle = out_handle_q;
	assign out_seq    = out_seq_q;
	assign status     = status_q;
	assign last       = last_q;

	// handle store
	srb_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (SLOT_COUNT)
	) u_handle_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_slot),
		.wdata (in_handle),
		.re    (ram_re),
		.raddr (exp_slot),
		.rdata (ram_rdata)
	);

	// a fetch always finds a buffered packet at the expected slot
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> slot_valid_q[exp_slot])
		else $error("fetch from an empty slot");

	// between packets the expected slot is never left occupied
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !slot_valid_q[exp_slot])
		else $error("run left undelivered");

	// input transfers only while no run is draining
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> (state_q == ST_IDLE))
		else $error("input taken during drain");

	// each fetch is followed by its output load stage
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_OUT))
		else $error("fetch not followed by load");

endmodule

`default_nettype wire
